// ===== design/lcc_pkg.sv =====
// shared types and constants for the luhn card number classifier
`timescale 1ns / 1ps
package lcc_pkg;

  // input and digit geometry
  localparam int CARD_W     = 63;
  localparam int NUM_DIGITS = 19;
  localparam int DIGIT_W    = 4;
  localparam int COUNT_W    = 5;
  localparam int TYPE_W     = 2;
  localparam int STEP_W     = 6;

  // last step index of each phase
  localparam logic [STEP_W-1:0] DABBLE_LAST = STEP_W'(CARD_W - 1);
  localparam logic [STEP_W-1:0] DRAIN_LAST  = STEP_W'(NUM_DIGITS - 1);

  // card type codes
  localparam logic [TYPE_W-1:0] TYPE_NONE  = 2'd0;
  localparam logic [TYPE_W-1:0] TYPE_LEAD4 = 2'd1;
  localparam logic [TYPE_W-1:0] TYPE_P3X   = 2'd2;
  localparam logic [TYPE_W-1:0] TYPE_P5X   = 2'd3;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DABBLE,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // control shared by the digit cells and the accumulator
  typedef struct packed {
    logic clr;
    logic dabble;
    logic drain;
  } ctrl_t;

endpackage

// ===== design/luhn_card_number_classifier_unit.sv =====
// top level: sequencer, input shift register, digit cell chain and accumulator
`timescale 1ns / 1ps
// Luhn card number classifier.
// An item is accepted at a rising edge with start high and busy low;
// card_number is sampled at that edge and busy stays high until the
// result has been shown.
// The number is converted to decimal by a chain of 19 digit cells that
// shift in one binary bit per cycle with add-three correction, then the
// digits drain out of the chain one per cycle, least significant first,
// into the accumulator.
// done is high for exactly one cycle, with card_type, checksum_ok and
// digit_count valid in that cycle. A new item can be accepted in the
// cycle after done; the bit shift through the cell chain takes up most
// of the time per item.
// The receiver cannot stall: the result is shown once and then dropped.
// Synchronous reset returns the sequencer to idle; any item in flight is
// lost and no result is shown for it.
module luhn_card_number_classifier_unit
  import lcc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [CARD_W-1:0]  card_number,
  output logic               busy,
  output logic               done,
  output logic [TYPE_W-1:0]  card_type,
  output logic               checksum_ok,
  output logic [COUNT_W-1:0] digit_count
);

  state_t            state;
  state_t            state_next;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic [CARD_W-1:0] shreg;
  ctrl_t             ctrl;

  logic [NUM_DIGITS:0]              bit_link;
  logic [NUM_DIGITS:0][DIGIT_W-1:0] digit_link;

  // state and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  // next state and control
  always_comb begin
    state_next  = state;
    step_next   = step;
    ctrl.clr    = 1'b0;
    ctrl.dabble = 1'b0;
    ctrl.drain  = 1'b0;
    busy        = 1'b1;
    done        = 1'b0;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctrl.clr   = 1'b1;
          step_next  = '0;
          state_next = ST_DABBLE;
        end
      end
      ST_DABBLE: begin
        ctrl.dabble = 1'b1;
        step_next   = step + 6'd1;
        if (step == DABBLE_LAST) begin
          step_next  = '0;
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        ctrl.drain = 1'b1;
        step_next  = step + 6'd1;
        if (step == DRAIN_LAST) begin
          step_next  = '0;
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        done       = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // input bits leave most significant first
  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      shreg <= card_number;
    end else if (ctrl.dabble) begin
      shreg <= {shreg[CARD_W-2:0], 1'b0};
    end
  end

  // chain ends: bits enter at the low cell, zeros enter the top while draining
  assign bit_link[0]            = shreg[CARD_W-1];
  assign digit_link[NUM_DIGITS] = '0;

  // row of digit cells, cell zero holds the least significant digit
  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    lcc_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .bit_in   (bit_link[i]),
      .digit_in (digit_link[i+1]),
      .bit_out  (bit_link[i+1]),
      .digit    (digit_link[i])
    );
  end

  // digits drain from cell zero into the accumulator
  lcc_acc u_acc (
    .clk         (clk),
    .ctrl        (ctrl),
    .digit_in    (digit_link[0]),
    .card_type   (card_type),
    .checksum_ok (checksum_ok),
    .digit_count (digit_count)
  );

endmodule

// ===== design/lcc_cell.sv =====
// one decimal digit cell of the binary to bcd chain
`timescale 1ns / 1ps
module lcc_cell
  import lcc_pkg::*;
(
  input  logic               clk,
  input  ctrl_t              ctrl,
  input  logic               bit_in,
  input  logic [DIGIT_W-1:0] digit_in,
  output logic               bit_out,
  output logic [DIGIT_W-1:0] digit
);

  logic [DIGIT_W-1:0] adj;

  // add three before the shift when the digit would overflow past nine
  always_comb begin
    adj = (digit >= 4'd5) ? digit + 4'd3 : digit;
  end

  assign bit_out = adj[DIGIT_W-1];

  // shift in a bit, or take the upper neighbor's digit while draining
  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      digit <= '0;
    end else if (ctrl.dabble) begin
      digit <= {adj[DIGIT_W-2:0], bit_in};
    end else if (ctrl.drain) begin
      digit <= digit_in;
    end
  end

endmodule

// ===== design/lcc_acc.sv =====
// luhn sum, digit count, prefix capture and card type decode
`timescale 1ns / 1ps
module lcc_acc
  import lcc_pkg::*;
(
  input  logic               clk,
  input  ctrl_t              ctrl,
  input  logic [DIGIT_W-1:0] digit_in,
  output logic [TYPE_W-1:0]  card_type,
  output logic               checksum_ok,
  output logic [COUNT_W-1:0] digit_count
);

  logic [DIGIT_W-1:0] sum;
  logic [COUNT_W-1:0] pos;
  logic [COUNT_W-1:0] count;
  logic [DIGIT_W-1:0] lead;
  logic [DIGIT_W-1:0] second;
  logic [DIGIT_W-1:0] prev;

  logic [DIGIT_W:0]   dbl;
  logic [DIGIT_W-1:0] weight;
  logic [DIGIT_W:0]   raw_sum;
  logic [DIGIT_W-1:0] sum_next;
  logic               ok;

  // odd positions from the right, counting from zero, are doubled, digits of the product added
  always_comb begin
    dbl = {digit_in, 1'b0};
    if (pos[0]) begin
      weight = (dbl > 5'd9) ? DIGIT_W'(dbl - 5'd9) : dbl[DIGIT_W-1:0];
    end else begin
      weight = digit_in;
    end
    raw_sum  = {1'b0, sum} + {1'b0, weight};
    sum_next = (raw_sum >= 5'd10) ? DIGIT_W'(raw_sum - 5'd10) : raw_sum[DIGIT_W-1:0];
  end

  // running state over digits, least significant first
  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      sum    <= '0;
      pos    <= '0;
      count  <= '0;
      lead   <= '0;
      second <= '0;
      prev   <= '0;
    end else if (ctrl.drain) begin
      sum  <= sum_next;
      pos  <= pos + 5'd1;
      prev <= digit_in;
      if (digit_in != '0) begin
        count  <= pos + 5'd1;
        lead   <= digit_in;
        second <= prev;
      end
    end
  end

  // zero input has no digits and never passes
  assign ok          = (sum == '0) && (count != '0);
  assign checksum_ok = ok;
  assign digit_count = count;

  // type from length and leading digits, only for a passing number
  always_comb begin
    card_type = TYPE_NONE;
    if (ok) begin
      if ((count == 5'd13 || count == 5'd16) && lead == 4'd4) begin
        card_type = TYPE_LEAD4;
      end else if (count == 5'd15 && lead == 4'd3 &&
                   (second == 4'd4 || second == 4'd7)) begin
        card_type = TYPE_P3X;
      end else if (count == 5'd16 && lead == 4'd5 &&
                   second >= 4'd1 && second <= 4'd5) begin
        card_type = TYPE_P5X;
      end
    end
  end

endmodule
